// File: src/mep_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// mep_pkg
// Shared types and constants of the escape-time evaluator with period check.
// ----------------------------------------------------------------------------
package mep_pkg;

  // configuration register indexes
  localparam logic [1:0] CFG_MAX_ITER   = 2'd0;
  localparam logic [1:0] CFG_BAILOUT_SQ = 2'd1;
  localparam logic [1:0] CFG_TOL_SQ     = 2'd2;

  // register widths and reset values
  localparam int unsigned MaxIterW  = 16;
  localparam int unsigned BailoutW  = 11;
  localparam int unsigned TolW      = 32;
  localparam int unsigned CfgDataW  = 32;
  localparam logic [MaxIterW-1:0] MaxIterRst = 16'd256;
  localparam logic [BailoutW-1:0] BailoutRst = 11'd256;
  localparam logic [TolW-1:0]     TolRst     = 32'd1099512;

  // period test: snapshot stride, last untested iteration, tolerance scale
  localparam int unsigned PeriodStride = 10;
  localparam int unsigned PeriodStart  = 10;
  localparam int unsigned TolFracBits  = 40;
  localparam int unsigned PhaseW       = 4;

  // outcome codes
  localparam logic [1:0] OUTCOME_ESCAPED  = 2'd0;
  localparam logic [1:0] OUTCOME_PERIODIC = 2'd1;
  localparam logic [1:0] OUTCOME_LIMIT    = 2'd2;
  localparam logic [1:0] OUTCOME_UNUSED   = 2'd3;

  // input item
  typedef struct packed {
    logic signed [31:0] c_real;
    logic signed [31:0] c_imag;
  } mep_in_t;

  // result item
  typedef struct packed {
    logic [15:0] iteration_value;
    logic [1:0]  outcome;
  } mep_out_t;

  // sequencer states
  typedef enum logic [3:0] {
    ST_IDLE,
    ST_XY_GO,
    ST_XY_WT,
    ST_RR_GO,
    ST_RR_WT,
    ST_II_GO,
    ST_II_WT,
    ST_ESC,
    ST_DR_GO,
    ST_DR_WT,
    ST_DI_GO,
    ST_DI_WT,
    ST_PER,
    ST_NEXT,
    ST_OUT
  } mep_state_e;

endpackage
`default_nettype wire

// File: src/mep_chan_if.sv
`default_nettype none
// ----------------------------------------------------------------------------
// mep_chan_if
// Valid/ready channel carrying one item of a given payload type.
// ----------------------------------------------------------------------------
interface mep_chan_if #(
  parameter type payload_t = logic
) ();

  logic     valid;
  logic     ready;
  payload_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);

endinterface
`default_nettype wire

// File: src/mep_mul.sv
`default_nettype none
// ----------------------------------------------------------------------------
// mep_mul
// Shared unsigned multiplier: four half-width partial products, one per
// cycle, accumulated into the full product; done_o marks the product valid.
// ----------------------------------------------------------------------------
module mep_mul
  import mep_pkg::*;
#(
  parameter int unsigned MW = 41
) (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire logic            start_i,
  input  wire logic [MW-1:0]   a_i,
  input  wire logic [MW-1:0]   b_i,
  output logic                 done_o,
  output logic [2*MW-1:0]      prod_o
);

  localparam int unsigned H  = (MW + 1) / 2;
  localparam int unsigned PW = 2 * MW;

  logic [2*H-1:0] a_q, b_q;
  logic [2*H-1:0] pp_q, pp_d;
  logic [1:0]     idx_q;
  logic           pp_v_q;
  logic [PW-1:0]  acc_q, acc_d;
  logic [2:0]     cnt_q;
  logic           run_q;

  // partial product select
  always_comb begin
    case (cnt_q[1:0])
      2'd0:    pp_d = a_q[H-1:0]   * b_q[H-1:0];
      2'd1:    pp_d = a_q[H-1:0]   * b_q[2*H-1:H];
      2'd2:    pp_d = a_q[2*H-1:H] * b_q[H-1:0];
      default: pp_d = a_q[2*H-1:H] * b_q[2*H-1:H];
    endcase
  end

  // weighted accumulate of the registered partial product
  always_comb begin
    case (idx_q)
      2'd0:    acc_d = acc_q + PW'(pp_q);
      2'd1,
      2'd2:    acc_d = acc_q + (PW'(pp_q) << H);
      default: acc_d = acc_q + (PW'(pp_q) << (2 * H));
    endcase
  end

  // sequence control
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      run_q  <= 1'b0;
      cnt_q  <= '0;
      pp_v_q <= 1'b0;
    end else if (start_i) begin
      run_q  <= 1'b1;
      cnt_q  <= '0;
      pp_v_q <= 1'b0;
    end else if (run_q) begin
      pp_v_q <= (cnt_q < 3'd4);
      if (cnt_q == 3'd5) begin
        run_q <= 1'b0;
      end else begin
        cnt_q <= cnt_q + 3'd1;
      end
    end
  end

  // operands, partial product and accumulator
  always_ff @(posedge clk_i) begin
    if (start_i) begin
      a_q   <= (2*H)'(a_i);
      b_q   <= (2*H)'(b_i);
      acc_q <= '0;
    end else if (run_q) begin
      if (cnt_q < 3'd4) begin
        pp_q  <= pp_d;
        idx_q <= cnt_q[1:0];
      end
      if (pp_v_q) begin
        acc_q <= acc_d;
      end
    end
  end

  assign done_o = run_q && (cnt_q == 3'd5);
  assign prod_o = acc_q;

endmodule
`default_nettype wire

// File: src/mandelbrot_escape_period_check_top.sv
`default_nettype none
// Sequence: an iteration runs three products, the escape test and the step;
// after iteration index 10 two more products and the period test come before
// the step. The result item loads once the result register is free.
// Flow: one item at a time; the next is taken in the idle state after the
// result loads. The shared multiplier, four partial products each, sets pace.
// Reset: registers return to max_iterations 256, bailout_sq 256,
// period_tol_sq 1099512; no item in flight and no result pending.
// ----------------------------------------------------------------------------
// mandelbrot_escape_period_check_top
// Escape-time evaluator of z = z*z + c with a snapshot-based period test.
// ----------------------------------------------------------------------------
module mandelbrot_escape_period_check_top
  import mep_pkg::*;
#(
  parameter int unsigned COORD_FRAC_BITS = 28
) (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                cfg_we_i,
  input  wire logic [1:0]          cfg_idx_i,
  input  wire logic [CfgDataW-1:0] cfg_data_i,
  mep_chan_if.sink                 in_i,
  mep_chan_if.source               out_o
);

  localparam int unsigned F   = COORD_FRAC_BITS;
  localparam int unsigned ZW  = ((F + 11 > 31) ? F + 11 : 31) + 2;
  localparam int unsigned SW  = 2 * ZW;
  localparam int unsigned DSH = (2 * F < TolFracBits) ? TolFracBits - 2 * F : 0;
  localparam int unsigned TSH = (2 * F > TolFracBits) ? 2 * F - TolFracBits : 0;
  localparam int unsigned AW  = (SW + 1 + DSH > TolW + TSH) ? SW + 1 + DSH : TolW + TSH;

  // configuration registers
  logic [MaxIterW-1:0] max_iter_q;
  logic [BailoutW-1:0] bailout_q;
  logic [TolW-1:0]     tol_q;

  // iteration state
  mep_state_e state_q, state_d;
  logic [MaxIterW-1:0] iter_q;
  logic [PhaseW-1:0]   phase_q;
  logic signed [31:0]  cr_q, ci_q;
  logic signed [ZW-1:0] zr_q, zi_q, sr_q, si_q;
  logic [SW-1:0]       sq_r_q, sq_i_q;
  logic [SW:0]         dsq_q;
  logic [15:0]         res_val_q;
  logic [1:0]          res_kind_q;
  logic                out_valid_q;
  mep_out_t            out_data_q;

  // multiplier interface
  logic                mul_start, mul_done;
  logic signed [ZW:0]  op_a_s, op_b_s;
  logic [ZW-1:0]       mag_a, mag_b;
  logic [SW-1:0]       prod;

  logic in_fire, out_free;
  logic esc_hit, per_hit, last_iter, dr_on;

  assign in_fire  = in_i.valid && in_i.ready;
  assign out_free = !out_valid_q || out_o.ready;

  // configuration writes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      max_iter_q <= MaxIterRst;
      bailout_q  <= BailoutRst;
      tol_q      <= TolRst;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_MAX_ITER:   max_iter_q <= cfg_data_i[MaxIterW-1:0];
        CFG_BAILOUT_SQ: bailout_q  <= cfg_data_i[BailoutW-1:0];
        CFG_TOL_SQ:     tol_q      <= cfg_data_i[TolW-1:0];
        default: ;
      endcase
    end
  end

  // differences to the snapshot
  logic signed [ZW:0] dr_s, di_s;
  assign dr_s = {zr_q[ZW-1], zr_q} - {sr_q[ZW-1], sr_q};
  assign di_s = {zi_q[ZW-1], zi_q} - {si_q[ZW-1], si_q};

  // operand magnitudes
  assign mag_a = op_a_s[ZW] ? ZW'(-op_a_s) : ZW'(op_a_s);
  assign mag_b = op_b_s[ZW] ? ZW'(-op_b_s) : ZW'(op_b_s);

  mep_mul #(
    .MW (ZW)
  ) u_mul (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (mul_start),
    .a_i     (mag_a),
    .b_i     (mag_b),
    .done_o  (mul_done),
    .prod_o  (prod)
  );

  // new z: real part from stored squares, imaginary from 2*re*im floored
  logic [SW:0]         two_p, q_w;
  logic                rem_nz, prod_neg;
  logic signed [ZW:0]  q_mag, fx_im, fx_rr, fx_ii, zr_new, zi_new;
  logic [SW-1:0]       rr_w, ii_w;

  always_comb begin
    two_p    = {prod, 1'b0};
    q_w      = two_p >> F;
    rem_nz   = |two_p[F-1:0];
    prod_neg = zr_q[ZW-1] ^ zi_q[ZW-1];
    q_mag    = $signed(q_w[ZW:0]) + $signed((ZW+1)'(rem_nz && prod_neg));
    fx_im    = prod_neg ? -q_mag : q_mag;
    rr_w     = sq_r_q >> F;
    ii_w     = sq_i_q >> F;
    fx_rr    = $signed({1'b0, rr_w[ZW-1:0]});
    fx_ii    = $signed({1'b0, ii_w[ZW-1:0]});
    zr_new   = fx_rr - fx_ii + (ZW+1)'(cr_q);
    zi_new   = fx_im + (ZW+1)'(ci_q);
  end

  // escape and period tests
  logic [SW:0] esc_sum, esc_bound;
  logic [AW-1:0] d_al, t_al;
  always_comb begin
    esc_sum   = {1'b0, sq_r_q} + {1'b0, sq_i_q};
    esc_bound = (SW+1)'(bailout_q) << (2 * F);
    esc_hit   = esc_sum > esc_bound;
    d_al      = AW'(dsq_q) << DSH;
    t_al      = AW'(tol_q) << TSH;
    per_hit   = d_al < t_al;
    dr_on     = iter_q > MaxIterW'(PeriodStart);
    last_iter = MaxIterW'(iter_q + 16'd1) == max_iter_q;
  end

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE:  if (in_fire) state_d = (max_iter_q == '0) ? ST_OUT : ST_XY_GO;
      ST_XY_GO: state_d = ST_XY_WT;
      ST_XY_WT: if (mul_done) state_d = ST_RR_GO;
      ST_RR_GO: state_d = ST_RR_WT;
      ST_RR_WT: if (mul_done) state_d = ST_II_GO;
      ST_II_GO: state_d = ST_II_WT;
      ST_II_WT: if (mul_done) state_d = ST_ESC;
      ST_ESC: begin
        if (esc_hit) state_d = ST_OUT;
        else if (dr_on) state_d = ST_DR_GO;
        else state_d = ST_NEXT;
      end
      ST_DR_GO: state_d = ST_DR_WT;
      ST_DR_WT: if (mul_done) state_d = ST_DI_GO;
      ST_DI_GO: state_d = ST_DI_WT;
      ST_DI_WT: if (mul_done) state_d = ST_PER;
      ST_PER:   state_d = per_hit ? ST_OUT : ST_NEXT;
      ST_NEXT:  state_d = last_iter ? ST_OUT : ST_XY_GO;
      ST_OUT:   if (out_free) state_d = ST_IDLE;
      default:  state_d = ST_IDLE;
    endcase
  end

  // state outputs: handshake and multiplier operands
  always_comb begin
    in_i.ready = (state_q == ST_IDLE);
    mul_start  = 1'b0;
    op_a_s     = {zr_q[ZW-1], zr_q};
    op_b_s     = {zr_q[ZW-1], zr_q};
    case (state_q)
      ST_XY_GO: begin
        mul_start = 1'b1;
        op_b_s    = {zi_q[ZW-1], zi_q};
      end
      ST_RR_GO: mul_start = 1'b1;
      ST_II_GO: begin
        mul_start = 1'b1;
        op_a_s    = {zi_q[ZW-1], zi_q};
        op_b_s    = {zi_q[ZW-1], zi_q};
      end
      ST_DR_GO: begin
        mul_start = 1'b1;
        op_a_s    = dr_s;
        op_b_s    = dr_s;
      end
      ST_DI_GO: begin
        mul_start = 1'b1;
        op_a_s    = di_s;
        op_b_s    = di_s;
      end
      default: ;
    endcase
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      iter_q      <= '0;
      phase_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (in_fire) begin
        iter_q  <= '0;
        phase_q <= '0;
      end else if (state_q == ST_NEXT) begin
        iter_q  <= iter_q + 16'd1;
        phase_q <= (phase_q == PhaseW'(PeriodStride - 1)) ? '0 : phase_q + 1'b1;
      end
      if (state_q == ST_OUT && out_free) begin
        out_valid_q <= 1'b1;
      end else if (out_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // datapath registers
  always_ff @(posedge clk_i) begin
    // new point: z, snapshot and squares start at zero
    if (in_fire) begin
      cr_q       <= in_i.data.c_real;
      ci_q       <= in_i.data.c_imag;
      zr_q       <= '0;
      zi_q       <= '0;
      sr_q       <= '0;
      si_q       <= '0;
      sq_r_q     <= '0;
      sq_i_q     <= '0;
      res_val_q  <= '0;
      res_kind_q <= OUTCOME_LIMIT;
    end
    // products come back
    if (mul_done) begin
      case (state_q)
        ST_XY_WT: begin
          zr_q <= zr_new[ZW-1:0];
          zi_q <= zi_new[ZW-1:0];
        end
        ST_RR_WT: sq_r_q <= prod;
        ST_II_WT: sq_i_q <= prod;
        ST_DR_WT: dsq_q  <= {1'b0, prod};
        ST_DI_WT: dsq_q  <= dsq_q + {1'b0, prod};
        default: ;
      endcase
    end
    // results
    if (state_q == ST_ESC && esc_hit) begin
      res_val_q  <= iter_q + 16'd1;
      res_kind_q <= OUTCOME_ESCAPED;
    end
    if (state_q == ST_PER && per_hit) begin
      res_val_q  <= max_iter_q - iter_q - 16'd1;
      res_kind_q <= OUTCOME_PERIODIC;
    end
    if (state_q == ST_NEXT) begin
      if (phase_q == '0) begin
        sr_q <= zr_q;
        si_q <= zi_q;
      end
      if (last_iter) begin
        res_val_q  <= max_iter_q;
        res_kind_q <= OUTCOME_LIMIT;
      end
    end
    // output register
    if (state_q == ST_OUT && out_free) begin
      out_data_q.iteration_value <= res_val_q;
      out_data_q.outcome         <= res_kind_q;
    end
  end

  assign out_o.valid = out_valid_q;
  assign out_o.data  = out_data_q;

  // a product only comes back while the sequencer waits for one
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    mul_done |-> (state_q == ST_XY_WT || state_q == ST_RR_WT || state_q == ST_II_WT ||
                  state_q == ST_DR_WT || state_q == ST_DI_WT))
    else $error("multiplier result outside a wait state");

  // a new result item only follows the hand-out state
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(state_q == ST_OUT))
    else $error("result item raised outside hand-out");

  // the unused outcome code never leaves the block
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q |-> out_data_q.outcome != OUTCOME_UNUSED)
    else $error("invalid outcome code");

endmodule
`default_nettype wire
